/* src/rpn_stack_bitwise_alu_core_macros.svh */
// Assertion macros for the RPN stack calculator checker.
`ifndef RPN_STACK_BITWISE_ALU_CORE_MACROS_SVH
`define RPN_STACK_BITWISE_ALU_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RPNSBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RPNSBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rpnsba_pkg.sv */
// Shared constants for the RPN stack calculator.
package rpnsba_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 16;
  localparam int CMD_W       = 4;
  localparam int STAT_W      = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_TOP   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SHL   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SHR   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_OR    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_AND   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_ADD   = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

endpackage

/* src/rpn_stack_bitwise_alu_core.sv */
// Operands are read from the stack memory into registered read ports when an
// item is accepted; the execute state then registers the result, waiting while
// the output register still holds an earlier result. A new item is accepted
// only after the previous one has finished its execute and write-back state.
// A finished result may wait at the output while the next item is accepted.
// Reset clears the stack count, the sequencer and the output valid; the stack
// memory itself is not cleared.
module rpn_stack_bitwise_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] operand_value
  input  logic [3:0]  in_tuser,   // [3:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result_value
  output logic [2:0]  out_tuser   // [0] result_valid, [2:1] status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic [rpnsba_pkg::DATA_W-1:0] stack_mem [rpnsba_pkg::STACK_DEPTH];

  logic                            state_r, state_nxt;
  logic [rpnsba_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [rpnsba_pkg::CMD_W-1:0]    cmd_r;
  logic [rpnsba_pkg::DATA_W-1:0]   val_r;
  logic [rpnsba_pkg::DATA_W-1:0]   rd_a_r, rd_b_r;
  logic                            out_tvalid_r;
  logic [rpnsba_pkg::DATA_W-1:0]   out_tdata_r;
  logic [2:0]                      out_tuser_r;

  logic                            in_fire;
  logic                            done;
  logic [rpnsba_pkg::PTR_W-1:0]    ptr_a, ptr_b;
  logic                            mem_we;
  logic [rpnsba_pkg::PTR_W-1:0]    mem_waddr;
  logic [rpnsba_pkg::DATA_W-1:0]   mem_wdata;
  logic                            res_valid;
  logic [rpnsba_pkg::DATA_W-1:0]   res_value;
  logic [rpnsba_pkg::STAT_W-1:0]   res_status;
  logic [rpnsba_pkg::DATA_W:0]     sum;
  logic                            big_shift;
  logic [rpnsba_pkg::DATA_W-1:0]   bin_r;
  logic                            two_ok;
  logic                            is_full;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign done       = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign ptr_a = cnt_r[rpnsba_pkg::PTR_W-1:0] - rpnsba_pkg::PTR_W'(1);
  assign ptr_b = cnt_r[rpnsba_pkg::PTR_W-1:0] - rpnsba_pkg::PTR_W'(2);

  assign sum       = {1'b0, rd_b_r} + {1'b0, rd_a_r};
  assign big_shift = (rd_a_r[rpnsba_pkg::DATA_W-1:4] != '0);
  assign two_ok    = (cnt_r >= rpnsba_pkg::CNT_W'(2));
  assign is_full   = (cnt_r == rpnsba_pkg::CNT_W'(rpnsba_pkg::STACK_DEPTH));

  always_comb begin
    bin_r = '0;
    unique case (cmd_r)
      rpnsba_pkg::CMD_SHL: bin_r = big_shift ? '0 : (rd_b_r << rd_a_r[3:0]);
      rpnsba_pkg::CMD_SHR: bin_r = big_shift ? '0 : (rd_b_r >> rd_a_r[3:0]);
      rpnsba_pkg::CMD_OR:  bin_r = rd_b_r | rd_a_r;
      rpnsba_pkg::CMD_AND: bin_r = rd_b_r & rd_a_r;
      rpnsba_pkg::CMD_ADD: bin_r = sum[rpnsba_pkg::DATA_W-1:0];
      default:             bin_r = '0;
    endcase
  end

  always_comb begin
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = rpnsba_pkg::ST_OK;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    mem_waddr  = ptr_b;
    mem_wdata  = bin_r;
    unique case (cmd_r)
      rpnsba_pkg::CMD_PUSH: begin
        if (is_full) begin
          res_status = rpnsba_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[rpnsba_pkg::PTR_W-1:0];
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + rpnsba_pkg::CNT_W'(1);
          res_valid = 1'b1;
          res_value = val_r;
        end
      end
      rpnsba_pkg::CMD_FLUSH: begin
        cnt_nxt = '0;
      end
      rpnsba_pkg::CMD_POP: begin
        if (cnt_r == '0) begin
          res_status = rpnsba_pkg::ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - rpnsba_pkg::CNT_W'(1);
          if (two_ok) begin
            res_valid = 1'b1;
            res_value = rd_b_r;
          end
        end
      end
      rpnsba_pkg::CMD_TOP: begin
        if (cnt_r == '0) begin
          res_status = rpnsba_pkg::ST_EMPTY;
        end else begin
          res_valid = 1'b1;
          res_value = rd_a_r;
        end
      end
      rpnsba_pkg::CMD_SHL, rpnsba_pkg::CMD_SHR, rpnsba_pkg::CMD_OR,
      rpnsba_pkg::CMD_AND, rpnsba_pkg::CMD_ADD: begin
        if (!two_ok) begin
          res_status = rpnsba_pkg::ST_EMPTY;
        end else if (cmd_r == rpnsba_pkg::CMD_ADD && sum[rpnsba_pkg::DATA_W]) begin
          res_status = rpnsba_pkg::ST_OVERFLOW;
        end else begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r - rpnsba_pkg::CNT_W'(1);
          res_valid = 1'b1;
          res_value = bin_r;
        end
      end
      default: begin
        res_status = rpnsba_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EXEC;
      S_EXEC:  if (done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (done && mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_a_r <= stack_mem[ptr_a];
      rd_b_r <= stack_mem[ptr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_tuser;
      val_r <= in_tdata;
    end
    if (done) begin
      out_tdata_r <= res_value;
      out_tuser_r <= {res_status, res_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        cnt_r        <= cnt_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

/* src/rpnsba_checker.sv */
// Port-level checker for the RPN stack calculator, bound to the top level.
`include "rpn_stack_bitwise_alu_core_macros.svh"

module rpnsba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [3:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);

  `RPNSBA_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_tvalid, "output valid after reset")
  `RPNSBA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `RPNSBA_ASSERT(a_null_zero, out_tvalid && !out_tuser[0] |-> out_tdata == 16'd0, "null result carries a value")
  `RPNSBA_ASSERT(a_err_null, out_tvalid && out_tuser[2:1] != rpnsba_pkg::ST_OK |-> !out_tuser[0], "error status with valid result")
  `RPNSBA_ASSERT(a_one_busy, in_tvalid && in_tready |=> !in_tready, "item accepted while busy")

endmodule

bind rpn_stack_bitwise_alu_core rpnsba_checker u_rpnsba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
